// ===== sv/gtr_pkg.sv =====
// gtr_pkg: shared types and constants of the gamepad typematic repeat core
// beat structs for both channels, register codes and lane timing controls
// no dependencies
`default_nettype none

package gtr_pkg;

  localparam int unsigned NUM_BUTTONS   = 15;
  localparam int unsigned NUM_AXES      = 6;
  localparam int unsigned NUM_CHANNELS  = NUM_BUTTONS + NUM_AXES;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned AXIS_BITS     = 16;
  localparam int unsigned MS_BITS       = 16;
  localparam int unsigned DZ_BITS       = 15;
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [MS_BITS-1:0] DELAY_RESET    = 16'd500;
  localparam logic [MS_BITS-1:0] RATE_RESET     = 16'd100;
  localparam logic [DZ_BITS-1:0] DEADZONE_RESET = 15'd8000;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_RATE     = 2'd1,
    REG_DEADZONE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]      button_bits;
    logic signed [AXIS_BITS-1:0] axis_raw_0;
    logic signed [AXIS_BITS-1:0] axis_raw_1;
    logic signed [AXIS_BITS-1:0] axis_raw_2;
    logic signed [AXIS_BITS-1:0] axis_raw_3;
    logic signed [AXIS_BITS-1:0] axis_raw_4;
    logic signed [AXIS_BITS-1:0] axis_raw_5;
    logic                        menu_mode;
    logic [TIME_BITS-1:0]        now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]      button_fire;
    logic signed [AXIS_BITS-1:0] axis_out_0;
    logic signed [AXIS_BITS-1:0] axis_out_1;
    logic signed [AXIS_BITS-1:0] axis_out_2;
    logic signed [AXIS_BITS-1:0] axis_out_3;
    logic signed [AXIS_BITS-1:0] axis_out_4;
    logic signed [AXIS_BITS-1:0] axis_out_5;
  } out_beat_t;

  // per-poll controls shared by every lane
  typedef struct packed {
    logic                 update;
    logic                 menu;
    logic [TIME_BITS-1:0] now;
    logic [MS_BITS-1:0]   delay;
    logic [MS_BITS-1:0]   rate;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/gtr_axis_class.sv =====
// gtr_axis_class: deadzone classifier of one axis into -1, 0 or +1
// depends on gtr_pkg
`default_nettype none

module gtr_axis_class
  import gtr_pkg::*;
(
  input  wire logic signed [AXIS_BITS-1:0] raw_i,
  input  wire logic [DZ_BITS-1:0]          deadzone_i,
  output logic signed [AXIS_BITS-1:0]      dir_o,
  output logic                             active_o
);

  logic signed [AXIS_BITS:0] v_ext;
  logic signed [AXIS_BITS:0] dz_pos;
  logic signed [AXIS_BITS:0] dz_neg;
  logic                      is_pos;
  logic                      is_neg;

  // one extra bit so that the most negative reading has its full magnitude
  assign v_ext  = {raw_i[AXIS_BITS-1], raw_i};
  assign dz_pos = $signed({2'b00, deadzone_i});
  assign dz_neg = (AXIS_BITS+1)'(0) - dz_pos;
  assign is_pos = v_ext > dz_pos;
  assign is_neg = v_ext < dz_neg;

  always_comb begin
    if (is_pos) begin
      dir_o = AXIS_BITS'(1);
    end else if (is_neg) begin
      dir_o = '1;
    end else begin
      dir_o = '0;
    end
  end

  assign active_o = is_pos | is_neg;

endmodule

`default_nettype wire

// ===== sv/gtr_lane.sv =====
// gtr_lane: repeat timer of one channel (press edge, delay, rate, release)
// depends on gtr_pkg
`default_nettype none

module gtr_lane
  import gtr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lane_ctrl_t ctrl_i,
  input  wire logic       menu_active_i,
  input  wire logic       pass_active_i,
  output logic            fire_o
);

  logic                 was_active_q, was_active_d;
  logic                 repeating_q, repeating_d;
  logic [TIME_BITS-1:0] ref_time_q, ref_time_d;
  logic [TIME_BITS-1:0] elapsed;
  logic [MS_BITS-1:0]   limit;

  // wraps modulo the timestamp width
  assign elapsed = ctrl_i.now - ref_time_q;
  assign limit   = repeating_q ? ctrl_i.rate : ctrl_i.delay;

  always_comb begin
    was_active_d = was_active_q;
    repeating_d  = repeating_q;
    ref_time_d   = ref_time_q;
    fire_o       = 1'b0;
    if (!ctrl_i.menu) begin
      was_active_d = pass_active_i;
      repeating_d  = 1'b0;
      ref_time_d   = ctrl_i.now;
    end else if (!menu_active_i) begin
      was_active_d = 1'b0;
      repeating_d  = 1'b0;
      ref_time_d   = ctrl_i.now;
    end else if (!was_active_q) begin
      fire_o       = 1'b1;
      was_active_d = 1'b1;
      repeating_d  = 1'b0;
      ref_time_d   = ctrl_i.now;
    end else if (elapsed >= TIME_BITS'(limit)) begin
      fire_o      = 1'b1;
      repeating_d = 1'b1;
      ref_time_d  = ctrl_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_active_q <= 1'b0;
      repeating_q  <= 1'b0;
      ref_time_q   <= '0;
    end else if (ctrl_i.update) begin
      was_active_q <= was_active_d;
      repeating_q  <= repeating_d;
      ref_time_q   <= ref_time_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gamepad_typematic_repeat_core.sv =====
// gamepad_typematic_repeat_core: typematic repeat and axis deadzone for one poll per beat
// a result beat is registered in the output register, or in the skid entry while output stalls
// throughput: one poll per cycle while the skid entry is empty; all 21 channel lanes update in parallel at acceptance
// a two-entry output (register plus skid) lets input run while output stalls one beat
// reset: async active low; clears lane state, registers to 500/100/8000, output empty
// depends on gtr_pkg, gtr_lane, gtr_axis_class
`default_nettype none

module gamepad_typematic_repeat_core
  import gtr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // poll channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire in_beat_t                 in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output out_beat_t                     out_data_o,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [MS_BITS-1:0] delay_q;
  logic [MS_BITS-1:0] rate_q;
  logic [DZ_BITS-1:0] deadzone_q;
  logic               cfg_write;
  reg_idx_e           cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  // word addressing, byte offset ignored
  assign cfg_idx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DELAY_RESET;
      rate_q     <= RATE_RESET;
      deadzone_q <= DEADZONE_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_DELAY:    delay_q    <= pwdata[MS_BITS-1:0];
        REG_RATE:     rate_q     <= pwdata[MS_BITS-1:0];
        REG_DEADZONE: deadzone_q <= pwdata[DZ_BITS-1:0];
        default:      ;  // unmapped register, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DELAY:    prdata = APB_DATA_BITS'(delay_q);
      REG_RATE:     prdata = APB_DATA_BITS'(rate_q);
      REG_DEADZONE: prdata = APB_DATA_BITS'(deadzone_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input acceptance and shared lane controls
  // ---------------------------------------------------------------------------
  logic       in_accept;
  lane_ctrl_t ctrl;

  assign in_accept   = in_valid_i & ~in_stall_o;
  assign ctrl.update = in_accept;
  assign ctrl.menu   = in_data_i.menu_mode;
  assign ctrl.now    = in_data_i.now_ms;
  assign ctrl.delay  = delay_q;
  assign ctrl.rate   = rate_q;

  // ---------------------------------------------------------------------------
  // axis classification, one classifier per axis
  // ---------------------------------------------------------------------------
  logic signed [AXIS_BITS-1:0] axis_raw [NUM_AXES];
  logic signed [AXIS_BITS-1:0] axis_dir [NUM_AXES];
  logic [NUM_AXES-1:0]         axis_menu_act;
  logic [NUM_AXES-1:0]         axis_pass_act;

  assign axis_raw[0] = in_data_i.axis_raw_0;
  assign axis_raw[1] = in_data_i.axis_raw_1;
  assign axis_raw[2] = in_data_i.axis_raw_2;
  assign axis_raw[3] = in_data_i.axis_raw_3;
  assign axis_raw[4] = in_data_i.axis_raw_4;
  assign axis_raw[5] = in_data_i.axis_raw_5;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    gtr_axis_class u_class (
      .raw_i      (axis_raw[a]),
      .deadzone_i (deadzone_q),
      .dir_o      (axis_dir[a]),
      .active_o   (axis_menu_act[a])
    );
    // in pass-through any nonzero reading counts as held
    assign axis_pass_act[a] = |axis_raw[a];
  end

  // ---------------------------------------------------------------------------
  // channel lanes: buttons first, then axes
  // ---------------------------------------------------------------------------
  logic [NUM_CHANNELS-1:0] menu_act;
  logic [NUM_CHANNELS-1:0] pass_act;
  logic [NUM_CHANNELS-1:0] fire;

  assign menu_act = {axis_menu_act, in_data_i.button_bits};
  assign pass_act = {axis_pass_act, in_data_i.button_bits};

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    gtr_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .menu_active_i (menu_act[c]),
      .pass_active_i (pass_act[c]),
      .fire_o        (fire[c])
    );
  end

  // ---------------------------------------------------------------------------
  // merge: build the result beat from lane fire bits and classifier outputs
  // ---------------------------------------------------------------------------
  logic signed [AXIS_BITS-1:0] axis_res [NUM_AXES];
  out_beat_t                   res_beat;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_merge
    // menu mode shows the direction only on a firing poll
    assign axis_res[a] = !in_data_i.menu_mode ? axis_raw[a] :
                         fire[NUM_BUTTONS + a] ? axis_dir[a] : '0;
  end

  // pass-through fire bits equal the raw levels
  assign res_beat.button_fire = in_data_i.menu_mode ? fire[NUM_BUTTONS-1:0]
                                                    : in_data_i.button_bits;
  assign res_beat.axis_out_0  = axis_res[0];
  assign res_beat.axis_out_1  = axis_res[1];
  assign res_beat.axis_out_2  = axis_res[2];
  assign res_beat.axis_out_3  = axis_res[3];
  assign res_beat.axis_out_4  = axis_res[4];
  assign res_beat.axis_out_5  = axis_res[5];

  // ---------------------------------------------------------------------------
  // output register with skid entry
  // ---------------------------------------------------------------------------
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t out_data_q, out_data_d;
  out_beat_t skid_data_q, skid_data_d;
  logic      out_take;

  assign out_take   = out_valid_q & ~out_stall_i;
  // input stalls only while the skid entry holds a beat
  assign in_stall_o = skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_data_d  = res_beat;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = res_beat;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== verif/tb_gamepad_typematic_repeat_core.sv =====
// tb_gamepad_typematic_repeat_core: self-checking bench for the typematic repeat core
// holds a poll-by-poll predictor of repeat timing and deadzone classification
// depends on gtr_pkg and gamepad_typematic_repeat_core

module tb_gamepad_typematic_repeat_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gtr_pkg::*;

  // address slot 3 has no register behind it, writes there must be dropped
  localparam int unsigned UNMAPPED_REG    = 3;
  localparam int          POLLS_PER_PHASE = 65;

  typedef int axis_ints_t [NUM_AXES];

  // scoreboard: mirrors the per-channel repeat state and queues report beats
  class repeat_scoreboard;
    logic [MS_BITS-1:0]   delay_ms;
    logic [MS_BITS-1:0]   rate_ms;
    logic [DZ_BITS-1:0]   deadzone;
    bit                   was_active [NUM_CHANNELS];
    bit                   repeating  [NUM_CHANNELS];
    logic [TIME_BITS-1:0] ref_time   [NUM_CHANNELS];
    out_beat_t            due_reports [$];
    int                   mismatches;
    int                   reports_seen;

    function new();
      delay_ms = DELAY_RESET;
      rate_ms  = RATE_RESET;
      deadzone = DEADZONE_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        was_active[c] = 1'b0;
        repeating[c]  = 1'b0;
        ref_time[c]   = '0;
      end
      mismatches   = 0;
      reports_seen = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [APB_DATA_BITS-1:0] value);
      case (idx)
        REG_DELAY:    delay_ms = value[MS_BITS-1:0];
        REG_RATE:     rate_ms  = value[MS_BITS-1:0];
        REG_DEADZONE: deadzone = value[DZ_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DATA_BITS-1:0] reg_value(int unsigned idx);
      case (idx)
        REG_DELAY:    return APB_DATA_BITS'(delay_ms);
        REG_RATE:     return APB_DATA_BITS'(rate_ms);
        REG_DEADZONE: return APB_DATA_BITS'(deadzone);
        default:      return '0;
      endcase
    endfunction

    // +1 above the deadzone, -1 when the magnitude is above it, else 0
    function int axis_dir(logic signed [AXIS_BITS-1:0] raw);
      int v;
      int mag;
      v   = raw;
      mag = (v < 0) ? -v : v;
      if (v > int'(deadzone)) return 1;
      if (mag > int'(deadzone)) return -1;
      return 0;
    endfunction

    // menu-mode channel, returns 1 when it fires on this poll
    function bit step_channel(int c, bit active, logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] elapsed;
      logic [MS_BITS-1:0]   limit;
      bit                   fire;
      fire = 1'b0;
      if (!active) begin
        was_active[c] = 1'b0;
        repeating[c]  = 1'b0;
        ref_time[c]   = now;
        return 1'b0;
      end
      if (!was_active[c]) begin
        fire         = 1'b1;
        repeating[c] = 1'b0;
        ref_time[c]  = now;
      end else begin
        elapsed = now - ref_time[c];
        limit   = repeating[c] ? rate_ms : delay_ms;
        if (elapsed >= TIME_BITS'(limit)) begin
          fire         = 1'b1;
          repeating[c] = 1'b1;
          ref_time[c]  = now;
        end
      end
      was_active[c] = 1'b1;
      return fire;
    endfunction

    function void take_poll(in_beat_t p);
      logic signed [AXIS_BITS-1:0] raw  [NUM_AXES];
      logic signed [AXIS_BITS-1:0] outs [NUM_AXES];
      out_beat_t                   want;
      int                          dir;
      int                          c;
      raw  = '{p.axis_raw_0, p.axis_raw_1, p.axis_raw_2,
               p.axis_raw_3, p.axis_raw_4, p.axis_raw_5};
      want = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (p.menu_mode) begin
          want.button_fire[b] = step_channel(b, p.button_bits[b], p.now_ms);
        end else begin
          ref_time[b]         = p.now_ms;
          repeating[b]        = 1'b0;
          was_active[b]       = p.button_bits[b];
          want.button_fire[b] = p.button_bits[b];
        end
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        c = NUM_BUTTONS + a;
        if (p.menu_mode) begin
          dir     = axis_dir(raw[a]);
          outs[a] = step_channel(c, dir != 0, p.now_ms) ? AXIS_BITS'(dir) : '0;
        end else begin
          ref_time[c]   = p.now_ms;
          repeating[c]  = 1'b0;
          was_active[c] = (raw[a] != 0);
          outs[a]       = raw[a];
        end
      end
      want.axis_out_0 = outs[0];
      want.axis_out_1 = outs[1];
      want.axis_out_2 = outs[2];
      want.axis_out_3 = outs[3];
      want.axis_out_4 = outs[4];
      want.axis_out_5 = outs[5];
      due_reports.push_back(want);
    endfunction

    task report(string what);
      // cap the log, the count keeps going
      if (mismatches < 100) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task match_report(out_beat_t got);
      out_beat_t                   want;
      logic signed [AXIS_BITS-1:0] g [NUM_AXES];
      logic signed [AXIS_BITS-1:0] w [NUM_AXES];
      if (due_reports.size() == 0) begin
        report($sformatf("report beat %0d with no poll pending: %h", reports_seen, got));
        reports_seen++;
        return;
      end
      want = due_reports.pop_front();
      if (got.button_fire !== want.button_fire)
        report($sformatf("beat %0d button_fire got %h want %h",
                         reports_seen, got.button_fire, want.button_fire));
      g = '{got.axis_out_0, got.axis_out_1, got.axis_out_2,
            got.axis_out_3, got.axis_out_4, got.axis_out_5};
      w = '{want.axis_out_0, want.axis_out_1, want.axis_out_2,
            want.axis_out_3, want.axis_out_4, want.axis_out_5};
      for (int a = 0; a < NUM_AXES; a++) begin
        if (g[a] !== w[a])
          report($sformatf("beat %0d axis_out_%0d got %0d want %0d",
                           reports_seen, a, g[a], w[a]));
      end
      reports_seen++;
    endtask
  endclass

  // clock, reset and every block input start at known values
  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        poll_valid = 1'b0;
  logic        poll_stall;
  in_beat_t    poll_data  = '0;
  logic        res_valid;
  logic        res_stall  = 1'b0;
  out_beat_t   res_data;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr  = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic        pready;

  repeat_scoreboard sb = new();

  // idling knobs, percent of cycles, set per phase
  int idle_pct  = 0;
  int stall_pct = 0;
  // long receiver hold-off: main flow posts a length, receiver counts it down
  int hold_req  = 0;
  int hold_left = 0;

  // slowly varying controller state so channels stay held long enough to repeat
  logic [NUM_BUTTONS-1:0] cur_buttons = '0;
  axis_ints_t             cur_axes    = '{default: 0};
  bit                     cur_menu    = 1'b1;
  // start close to the top so the timestamp wraps early in the random part
  logic [TIME_BITS-1:0]   cur_now     = 32'hFFFF_F000;

  gamepad_typematic_repeat_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poll_valid),
    .in_stall_o  (poll_stall),
    .in_data_i   (poll_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver side: random stall, or a counted long hold-off when one is posted
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // both handshakes sampled at the rising edge; the poll is noted first so
  // the ordering holds even if a report beat came out in the same cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (poll_valid && !poll_stall) sb.take_poll(poll_data);
      if (res_valid && !res_stall) sb.match_report(res_data);
    end
  end

  function automatic in_beat_t poll_of(logic [NUM_BUTTONS-1:0] buttons, axis_ints_t ax,
                                       bit menu, logic [TIME_BITS-1:0] now);
    in_beat_t p;
    p.button_bits = buttons;
    p.axis_raw_0  = AXIS_BITS'(ax[0]);
    p.axis_raw_1  = AXIS_BITS'(ax[1]);
    p.axis_raw_2  = AXIS_BITS'(ax[2]);
    p.axis_raw_3  = AXIS_BITS'(ax[3]);
    p.axis_raw_4  = AXIS_BITS'(ax[4]);
    p.axis_raw_5  = AXIS_BITS'(ax[5]);
    p.menu_mode   = menu;
    p.now_ms      = now;
    return p;
  endfunction

  // axis readings clustered on the deadzone edges and the rails
  function automatic int pick_axis();
    int dz;
    int v;
    dz = int'(sb.deadzone);
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = dz;
      2:       v = dz + 1;
      3:       v = -dz;
      4:       v = -dz - 1;
      5:       v = 32767;
      6:       v = -32768;
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // mostly held controls with occasional press/release, some pure noise polls
  task automatic make_poll(output in_beat_t p);
    axis_ints_t ax;
    int         r;
    if ($urandom_range(99) < 8) begin
      for (int a = 0; a < NUM_AXES; a++) ax[a] = int'($urandom_range(65535)) - 32768;
      p = poll_of(NUM_BUTTONS'($urandom), ax, 1'($urandom), $urandom);
      return;
    end
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if ($urandom_range(9) == 0) cur_buttons[b] = ~cur_buttons[b];
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      if ($urandom_range(9) == 0) cur_axes[a] = pick_axis();
    end
    if ($urandom_range(24) == 0) cur_menu = ~cur_menu;
    // time steps: mostly short, some long, rare big jumps, a few repeats of now
    r = $urandom_range(99);
    if (r >= 97) cur_now += $urandom;
    else if (r >= 12) cur_now += $urandom_range(1, 150);
    else if (r >= 5) cur_now += $urandom_range(151, 2000);
    p = poll_of(cur_buttons, cur_axes, cur_menu, cur_now);
  endtask

  // drive one poll at the falling edge, hold it until the block takes it;
  // valid stays up afterwards so back-to-back beats follow without a gap
  task automatic send_poll(in_beat_t p);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      poll_valid <= 1'b0;
    end
    @(negedge clk_i);
    poll_valid <= 1'b1;
    poll_data  <= p;
    do @(posedge clk_i); while (poll_stall);
  endtask

  // drop valid, wait until every report is back, then let the block settle
  task automatic wait_drained();
    int spins;
    @(negedge clk_i);
    poll_valid <= 1'b0;
    spins = 0;
    while (sb.due_reports.size() != 0 && spins < 5000) begin
      @(posedge clk_i);
      spins++;
    end
    if (sb.due_reports.size() != 0) begin
      sb.report($sformatf("%0d report beats never arrived", sb.due_reports.size()));
      sb.due_reports.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // apb write (setup then access), then read a mapped register back
  task automatic cfg_write(int unsigned idx, logic [APB_DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    if (idx <= REG_DEADZONE) begin
      @(negedge clk_i);
      psel <= 1'b1;
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata !== sb.reg_value(idx))
        sb.report($sformatf("register %0d reads %h want %h", idx, prdata,
                            sb.reg_value(idx)));
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // one configuration setting plus one idling pattern; optional long
  // receiver hold-off early on and a sender pause half way through
  task automatic run_phase(int unsigned delay, int unsigned rate, int unsigned dz,
                           int idle, int stall, int hold, bit pause);
    in_beat_t p;
    wait_drained();
    cfg_write(REG_DELAY, delay);
    cfg_write(REG_RATE, rate);
    cfg_write(REG_DEADZONE, dz);
    cfg_write(UNMAPPED_REG, $urandom);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < POLLS_PER_PHASE; i++) begin
      if (hold != 0 && i == 10) hold_req = hold;
      if (pause && i == POLLS_PER_PHASE / 2) wait_drained();
      make_poll(p);
      send_poll(p);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed polls at the reset setting (delay 500, rate 100, deadzone 8000)
    // pass-through, all released then all held, axes at the rails, near zero and at the deadzone edge
    send_poll(poll_of(15'h0000, '{0, 0, 0, 0, 0, 0}, 1'b0, 32'd0));
    send_poll(poll_of(15'h7FFF, '{32767, -32768, 1, -1, 8000, -8001}, 1'b0, 32'd100));
    // entering menu mode while held is no press edge, delay counts from last poll
    send_poll(poll_of(15'h7FFF, '{32767, -32768, 1, -1, 8000, -8001}, 1'b1, 32'd200));
    // first repeat exactly at the delay, then one short of the rate, then on it
    send_poll(poll_of(15'h7FFF, '{32767, -32768, 1, -1, 8000, -8001}, 1'b1, 32'd600));
    send_poll(poll_of(15'h7FFF, '{32767, -32768, 1, -1, 8000, -8001}, 1'b1, 32'd699));
    send_poll(poll_of(15'h7FFF, '{32767, -32768, 1, -1, 8000, -8001}, 1'b1, 32'd700));
    // release everything
    send_poll(poll_of(15'h0000, '{0, 0, 0, 0, 0, 0}, 1'b1, 32'd710));
    // press edges, axes on both sides of the deadzone edge
    send_poll(poll_of(15'h5555, '{8001, -8001, 8000, -8000, 32767, -32768}, 1'b1, 32'd720));
    // axis 0 flips direction without passing zero: still held, fires as -1 later
    send_poll(poll_of(15'h5555, '{-9000, -8001, 8000, -8000, 32767, -32768}, 1'b1, 32'd730));
    send_poll(poll_of(15'h5555, '{-9000, -8001, 8000, -8000, 32767, -32768}, 1'b1, 32'd1220));
    // press just before the timestamp wraps, repeats measured across the wrap
    send_poll(poll_of(15'h0000, '{0, 0, 0, 0, 0, 0}, 1'b1, 32'hFFFF_FE00));
    send_poll(poll_of(15'h2AAA, '{0, 0, 0, 0, 0, 9000}, 1'b1, 32'hFFFF_FF00));
    send_poll(poll_of(15'h2AAA, '{0, 0, 0, 0, 0, 9000}, 1'b1, 32'h0000_00F3));
    send_poll(poll_of(15'h2AAA, '{0, 0, 0, 0, 0, 9000}, 1'b1, 32'h0000_00F4));
    send_poll(poll_of(15'h2AAA, '{0, 0, 0, 0, 0, 9000}, 1'b1, 32'h0000_0158));
    // back to pass-through, top timestamp
    send_poll(poll_of(15'h7FFF, '{-32768, 32767, -1, 1, 0, 12345}, 1'b0, 32'h1234_5678));
    send_poll(poll_of(15'h0000, '{-32768, -32768, -32768, -32768, -32768, -32768},
                      1'b0, 32'hFFFF_FFFF));

    // random phases over the settings, extremes included
    run_phase(DELAY_RESET, RATE_RESET, DEADZONE_RESET, 0, 0, 120, 1'b0);
    run_phase(0, 0, 0, 75, 0, 0, 1'b1);
    run_phase(65535, 65535, 32767, 0, 75, 0, 1'b0);
    run_phase(40, 15, 1000, 32, 32, 150, 1'b0);
    run_phase(300, 0, 20000, 0, 0, 0, 1'b1);
    run_phase($urandom_range(1000), $urandom_range(300), $urandom_range(32767),
              32, 32, 0, 1'b0);

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
